// ===== design/swpb_pkg.sv =====
// Shared types and constants of the sliding window packet buffer.
package swpb_pkg;

   localparam int SEQ_W      = 32;
   localparam int DATA_W     = 64;
   localparam int SIZE_W     = 16;
   localparam int WIDX_W     = 4;
   localparam int WIN_W      = 9;
   localparam int WORDS_W    = 5;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int RESULT_CAP = 16;

   localparam logic [SEQ_W-1:0] INIT_SEQ_RST  = '0;
   localparam logic [WIN_W-1:0] WIN_RST       = 9'd8;
   localparam logic [WORDS_W-1:0] WORDS_RST   = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_WORDS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SEQ     = 2'd2;

   typedef enum logic [2:0] {
      OP_RESET   = 3'd0,
      OP_ADD     = 3'd1,
      OP_REPLACE = 3'd2,
      OP_GET     = 3'd3,
      OP_GET_LOW = 3'd4,
      OP_QUERY   = 3'd5,
      OP_SLIDE   = 3'd6,
      OP_COUNT   = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEQ_GO,
      ST_SEQ_WAIT,
      ST_BASE_GO,
      ST_BASE_WAIT,
      ST_CLEAR,
      ST_STORE,
      ST_FINISH,
      ST_SCAN,
      ST_RD,
      ST_GET,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [SEQ_W-1:0] dividend;
   } rem_ctl_type;

   typedef struct packed {
      logic             done;
      logic [WIN_W-1:0] rem;
   } rem_stat_type;

   typedef struct packed {
      logic               status;
      logic [DATA_W-1:0]  out_data_word;
      logic [SIZE_W-1:0]  out_data_size;
      logic [WIDX_W-1:0]  out_word_index;
      logic               last_result;
      logic               window_open;
      logic               entry_valid;
      logic [COUNT_W-1:0] in_order_count;
      logic [SEQ_W-1:0]   lower_seq;
   } rsp_type;

endpackage

// ===== design/swpb_req_if.sv =====
// Request channel of the packet buffer.
interface swpb_req_if
   import swpb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [2:0]        op;
   logic [SEQ_W-1:0]  seq_num;
   logic [SIZE_W-1:0] data_size;
   logic [WIDX_W-1:0] word_index;
   logic [DATA_W-1:0] data_word;
   logic              last_word;

   modport source (output valid, op, seq_num, data_size, word_index, data_word, last_word,
                   input ready);
   modport sink   (input valid, op, seq_num, data_size, word_index, data_word, last_word,
                   output ready);
endinterface

// ===== design/swpb_rsp_if.sv =====
// Response channel of the packet buffer.
interface swpb_rsp_if
   import swpb_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               status;
   logic [DATA_W-1:0]  out_data_word;
   logic [SIZE_W-1:0]  out_data_size;
   logic [WIDX_W-1:0]  out_word_index;
   logic               last_result;
   logic               window_open;
   logic               entry_valid;
   logic [COUNT_W-1:0] in_order_count;
   logic [SEQ_W-1:0]   lower_seq;

   modport source (output valid, status, out_data_word, out_data_size, out_word_index,
                   last_result, window_open, entry_valid, in_order_count, lower_seq,
                   input ready);
   modport sink   (input valid, status, out_data_word, out_data_size, out_word_index,
                   last_result, window_open, entry_valid, in_order_count, lower_seq,
                   output ready);
endinterface

// ===== design/swpb_rem.sv =====
// Bit-serial remainder unit: dividend modulo window size, one bit per cycle.
module swpb_rem
   import swpb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rem_ctl_type      ctl,
   input  logic [WIN_W-1:0] divisor,
   output rem_stat_type     stat
);
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [SEQ_W-1:0] num_ff, num_in;
   logic [WIN_W-1:0] rem_ff, rem_in;
   logic [WIN_W:0]   trial;

   assign trial = {rem_ff, num_ff[SEQ_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = ctl.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = WIN_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[WIN_W-1:0];
         end
         num_in = {num_ff[SEQ_W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;
endmodule

// ===== design/sliding_window_packet_buffer.sv =====
// Selective-repeat sliding window packet buffer, top level.
//
// Packets live in slots picked by sequence number modulo the window size;
// the window has lower, current and upper edges. Add and replace words are
// staged one per transfer; the transfer with last_word set commits the
// packet. Get ops stream the stored packet one word per response transfer.
// Timing: one request is worked on at a time and req ready is low
// meanwhile. A non-final add/replace word is only staged and ready stays
// high. Every other op except reset runs the shared bit-serial remainder
// unit, each use a start state and then a wait for its done flag:
// once for get, query, replace and a rejected add, twice for an accepted
// add, get lowest, slide and in-order count (the second pass finds the slot
// of an edge). Then gap invalidation on add and slot invalidation on slide
// walk one slot per cycle (up to window size), a commit writes one packet
// word per cycle (packet_words) and then sets the valid mark, the
// in-order count walks one slot per cycle until it stops, and a get reads
// each word in a read state and hands it out from a get state. Other ops
// load a single response from the result state after the work ends.
// Stalls on rsp ready hold the get and result states.
// Op reset clears the slot valid and size marks, staging words and edges
// when accepted, and its response is loaded from the result state.
// Payload words of a slot never written read as unspecified data.
module sliding_window_packet_buffer
   import swpb_pkg::*;
#(
   parameter int MAX_WINDOW   = 256,
   parameter int PACKET_WORDS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   swpb_req_if.sink              req_chan,
   swpb_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int SLOT_W   = $clog2(MAX_WINDOW);
   localparam int SI_W     = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
   localparam int DEPTH    = MAX_WINDOW * PACKET_WORDS;
   localparam int AW       = $clog2(DEPTH);
   localparam int WORD_LIM = (PACKET_WORDS < RESULT_CAP) ? PACKET_WORDS : RESULT_CAP;
   localparam int RST_WIN  = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

   // configuration
   logic [WIN_W-1:0]   win_cfg_ff;
   logic [WORDS_W-1:0] words_cfg_ff;
   logic [SEQ_W-1:0]   init_seq_ff;
   logic [WIN_W-1:0]   w_eff;
   logic [WORDS_W-1:0] p_eff;

   // window state
   logic [MAX_WINDOW-1:0] valid_ff;
   logic [MAX_WINDOW-1:0] size_ok_ff;     // size entry holds a real value
   logic [DATA_W-1:0]     stage_ff [PACKET_WORDS];
   logic [SEQ_W-1:0]      lower_ff, current_ff, upper_ff;

   // request work registers
   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic               status_ff;
   logic [SLOT_W-1:0]  slot_ff, idx_ff;
   logic [WIN_W-1:0]   cnt_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [SEQ_W-1:0]   pos_ff;
   logic [WIDX_W-1:0]  k_ff;

   // memories
   logic [DATA_W-1:0] payload_mem [DEPTH];
   logic [SIZE_W-1:0] size_mem [MAX_WINDOW];
   logic [DATA_W-1:0] rd_data_ff;
   logic [SIZE_W-1:0] size_rd_ff;
   logic [AW-1:0]     mem_addr;
   logic              mem_we;

   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // remainder unit
   rem_ctl_type  rem_ctl;
   rem_stat_type rem_stat;

   // helpers
   logic              accept, out_free, closed, gap, k_last, scan_go, rsp_load;
   logic [SEQ_W-1:0]  gap_from, gap_diff;
   logic [WIN_W-1:0]  gap_n;
   logic [SLOT_W-1:0] idx_next;
   logic [SLOT_W-1:0] rem_slot;

   swpb_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rem_ctl),
      .divisor (w_eff),
      .stat    (rem_stat)
   );

   // effective register values
   always_comb begin
      w_eff = win_cfg_ff;
      if (win_cfg_ff == '0) begin
         w_eff = WIN_W'(1);
      end else if (32'(win_cfg_ff) > MAX_WINDOW) begin
         w_eff = WIN_W'(MAX_WINDOW);
      end
      p_eff = words_cfg_ff;
      if (words_cfg_ff == '0) begin
         p_eff = WORDS_W'(1);
      end else if (32'(words_cfg_ff) > WORD_LIM) begin
         p_eff = WORDS_W'(WORD_LIM);
      end
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = ((state_ff == ST_GET) || (state_ff == ST_RESULT)) && out_free;
   assign closed   = (current_ff == upper_ff);
   assign gap_from = (op_ff == OP_ADD) ? current_ff : lower_ff;
   assign gap      = (seq_ff > gap_from);
   assign gap_diff = seq_ff - gap_from;
   assign gap_n    = (gap_diff > 32'(w_eff)) ? w_eff : gap_diff[WIN_W-1:0];
   assign k_last   = (k_ff == WIDX_W'(p_eff - WORDS_W'(1)));
   assign idx_next = (32'(idx_ff) + 32'd1 == 32'(w_eff)) ? '0 : SLOT_W'(idx_ff + 1'b1);
   assign scan_go  = (pos_ff < current_ff) && (count_ff < w_eff) && valid_ff[idx_ff];
   assign rem_slot = SLOT_W'(rem_stat.rem);
   assign mem_addr = AW'(32'(slot_ff) * 32'(PACKET_WORDS) + 32'(k_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_chan.op) == OP_RESET) begin
                  state_in = ST_RESULT;
               end else if (op_type'(req_chan.op) inside {OP_ADD, OP_REPLACE}) begin
                  state_in = req_chan.last_word ? ST_SEQ_GO : ST_IDLE;
               end else begin
                  state_in = ST_SEQ_GO;
               end
            end
         end
         ST_SEQ_GO:  state_in = ST_SEQ_WAIT;
         ST_SEQ_WAIT: begin
            if (rem_stat.done) begin
               case (op_ff)
                  OP_ADD:     state_in = closed ? ST_RESULT : ST_BASE_GO;
                  OP_REPLACE: state_in = ST_STORE;
                  OP_GET:     state_in = ST_RD;
                  OP_QUERY:   state_in = ST_RESULT;
                  default:    state_in = ST_BASE_GO;
               endcase
            end
         end
         ST_BASE_GO: state_in = ST_BASE_WAIT;
         ST_BASE_WAIT: begin
            if (rem_stat.done) begin
               case (op_ff)
                  OP_ADD:     state_in = gap ? ST_CLEAR : ST_STORE;
                  OP_SLIDE:   state_in = gap ? ST_CLEAR : ST_FINISH;
                  OP_GET_LOW: state_in = ST_RD;
                  default:    state_in = ST_SCAN;
               endcase
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == WIN_W'(1)) begin
               state_in = (op_ff == OP_ADD) ? ST_STORE : ST_FINISH;
            end
         end
         ST_STORE:  state_in = k_last ? ST_FINISH : ST_STORE;
         ST_FINISH: state_in = ST_RESULT;
         ST_SCAN:   state_in = scan_go ? ST_SCAN : ST_RESULT;
         ST_RD:     state_in = ST_GET;
         ST_GET: begin
            if (out_free) begin
               state_in = k_last ? ST_IDLE : ST_RD;
            end
         end
         ST_RESULT: state_in = out_free ? ST_IDLE : ST_RESULT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready   = (state_ff == ST_IDLE);
      rem_ctl.start    = (state_ff == ST_SEQ_GO) || (state_ff == ST_BASE_GO);
      rem_ctl.dividend = (state_ff == ST_SEQ_GO) ? seq_ff : gap_from;
      mem_we           = (state_ff == ST_STORE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload and size memories, registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[mem_addr] <= stage_ff[SI_W'(k_ff)];
      end
      if (state_ff == ST_FINISH && (op_ff == OP_ADD || op_ff == OP_REPLACE)) begin
         size_mem[slot_ff] <= size_ff;
      end
      rd_data_ff <= payload_mem[mem_addr];
      size_rd_ff <= size_mem[slot_ff];
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff   <= WIN_RST;
         words_cfg_ff <= WORDS_RST;
         init_seq_ff  <= INIT_SEQ_RST;
         valid_ff     <= '0;
         size_ok_ff   <= '0;
         for (int i = 0; i < PACKET_WORDS; i++) begin
            stage_ff[i] <= '0;
         end
         lower_ff     <= INIT_SEQ_RST;
         current_ff   <= INIT_SEQ_RST;
         upper_ff     <= INIT_SEQ_RST + SEQ_W'(RST_WIN);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_SIZE:  win_cfg_ff   <= csr_wdata[WIN_W-1:0];
               CSR_PACKET_WORDS: words_cfg_ff <= csr_wdata[WORDS_W-1:0];
               CSR_INIT_SEQ:     init_seq_ff  <= csr_wdata[SEQ_W-1:0];
               default: ;
            endcase
         end
         // a new response may be loaded in the cycle the old one transfers
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff     <= op_type'(req_chan.op);
                  seq_ff    <= req_chan.seq_num;
                  size_ff   <= req_chan.data_size;
                  status_ff <= 1'b0;
                  count_ff  <= '0;
                  if (op_type'(req_chan.op) == OP_RESET) begin
                     valid_ff   <= '0;
                     size_ok_ff <= '0;
                     for (int i = 0; i < PACKET_WORDS; i++) begin
                        stage_ff[i] <= '0;
                     end
                     lower_ff   <= init_seq_ff;
                     current_ff <= init_seq_ff;
                     upper_ff   <= init_seq_ff + SEQ_W'(w_eff);
                  end else if (op_type'(req_chan.op) inside {OP_ADD, OP_REPLACE}) begin
                     if (32'(req_chan.word_index) < PACKET_WORDS) begin
                        stage_ff[SI_W'(req_chan.word_index)] <= req_chan.data_word;
                     end
                  end
               end
            end
            ST_SEQ_WAIT: begin
               if (rem_stat.done) begin
                  slot_ff <= rem_slot;
                  k_ff    <= '0;
                  if (op_ff == OP_ADD && closed) begin
                     status_ff <= 1'b1;
                  end
               end
            end
            ST_BASE_WAIT: begin
               if (rem_stat.done) begin
                  idx_ff   <= rem_slot;
                  cnt_ff   <= gap_n;
                  pos_ff   <= lower_ff;
                  count_ff <= '0;
                  k_ff     <= '0;
                  if (op_ff == OP_GET_LOW) begin
                     slot_ff <= rem_slot;
                  end
               end
            end
            ST_CLEAR: begin
               valid_ff[idx_ff] <= 1'b0;
               if (op_ff == OP_ADD) begin
                  size_ok_ff[idx_ff] <= 1'b0;
               end
               idx_ff <= idx_next;
               cnt_ff <= cnt_ff - WIN_W'(1);
            end
            ST_STORE: begin
               if (!k_last) begin
                  k_ff <= k_ff + WIDX_W'(1);
               end
            end
            ST_FINISH: begin
               if (op_ff == OP_ADD || op_ff == OP_REPLACE) begin
                  valid_ff[slot_ff]   <= 1'b1;
                  size_ok_ff[slot_ff] <= 1'b1;
               end
               if (op_ff == OP_ADD) begin
                  current_ff <= seq_ff + SEQ_W'(1);
               end
               if (op_ff == OP_SLIDE) begin
                  lower_ff <= seq_ff;
                  upper_ff <= seq_ff + SEQ_W'(w_eff);
               end
            end
            ST_SCAN: begin
               if (scan_go) begin
                  count_ff <= count_ff + COUNT_W'(1);
                  pos_ff   <= pos_ff + SEQ_W'(1);
                  idx_ff   <= idx_next;
               end
            end
            ST_GET: begin
               if (out_free) begin
                  rsp_ff.status         <= 1'b0;
                  rsp_ff.out_data_word  <= rd_data_ff;
                  rsp_ff.out_data_size  <= size_ok_ff[slot_ff] ? size_rd_ff : '0;
                  rsp_ff.out_word_index <= k_ff;
                  rsp_ff.last_result    <= k_last;
                  rsp_ff.window_open    <= !closed;
                  rsp_ff.entry_valid    <= valid_ff[slot_ff];
                  rsp_ff.in_order_count <= '0;
                  rsp_ff.lower_seq      <= lower_ff;
                  if (!k_last) begin
                     k_ff <= k_ff + WIDX_W'(1);
                  end
               end
            end
            ST_RESULT: begin
               if (out_free) begin
                  rsp_ff.status         <= status_ff;
                  rsp_ff.out_data_word  <= '0;
                  rsp_ff.out_data_size  <= '0;
                  rsp_ff.out_word_index <= '0;
                  rsp_ff.last_result    <= 1'b1;
                  rsp_ff.window_open    <= !closed;
                  // after op reset every slot is invalid
                  rsp_ff.entry_valid    <= (op_ff == OP_RESET) ? 1'b0 : valid_ff[slot_ff];
                  rsp_ff.in_order_count <= (op_ff == OP_COUNT) ? count_ff : '0;
                  rsp_ff.lower_seq      <= lower_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.out_data_word  = rsp_ff.out_data_word;
   assign rsp_chan.out_data_size  = rsp_ff.out_data_size;
   assign rsp_chan.out_word_index = rsp_ff.out_word_index;
   assign rsp_chan.last_result    = rsp_ff.last_result;
   assign rsp_chan.window_open    = rsp_ff.window_open;
   assign rsp_chan.entry_valid    = rsp_ff.entry_valid;
   assign rsp_chan.in_order_count = rsp_ff.in_order_count;
   assign rsp_chan.lower_seq      = rsp_ff.lower_seq;
endmodule

// ===== design/swpb_chk.sv =====
// Port-level checks of the packet buffer, bound to the top level.
module swpb_chk
   import swpb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               status,
   input logic [DATA_W-1:0]  out_data_word,
   input logic [WIDX_W-1:0]  out_word_index,
   input logic               last_result,
   input logic [COUNT_W-1:0] in_order_count
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status) |-> (out_data_word == '0 && out_word_index == '0 && last_result))
      else $error("rejected add carries data");

   a_count_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && in_order_count != '0) |-> (last_result && !status))
      else $error("count on a non-final response");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_data_word)))
      else $error("stalled response changed");
endmodule

bind sliding_window_packet_buffer swpb_chk u_swpb_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .status         (rsp_chan.status),
   .out_data_word  (rsp_chan.out_data_word),
   .out_word_index (rsp_chan.out_word_index),
   .last_result    (rsp_chan.last_result),
   .in_order_count (rsp_chan.in_order_count)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the sliding window packet buffer.
module testbench;
   import swpb_pkg::*;

   localparam int SLOTS     = 256;
   localparam int WORDS_MAX = 16;
   // Worst single request: two remainder passes, a full-window walk and a commit.
   localparam int SETTLE    = 600;

   typedef struct {
      op_type       op;
      logic [31:0]  seq;
      logic [15:0]  size;
      logic [3:0]   widx;
      logic [63:0]  word;
      bit           last;
      bit           typed;
      rsp_type      res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   swpb_req_if req ();
   swpb_rsp_if rsp ();

   sliding_window_packet_buffer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------
   // Window model: registers, slot store and the lower, current and upper edges
   // ---------------------------------------------------------------
   logic [8:0]  win_reg;
   logic [4:0]  words_reg;
   logic [31:0] init_seq_reg;
   bit          slot_ok   [SLOTS];
   logic [15:0] slot_len  [SLOTS];
   logic [63:0] pkt_mem   [SLOTS*WORDS_MAX];
   bit          pkt_known [SLOTS*WORDS_MAX];   // word written since the last reset
   logic [63:0] stage_mem [WORDS_MAX];
   bit          stage_known [WORDS_MAX];
   logic [31:0] low_edge, cur_edge, up_edge;

   rsp_type expected_rsp_q[$];
   int req_xfers, rsp_xfers, fails, phases;

   function automatic int unsigned win_eff();
      if (win_reg == 0) return 1;
      if (win_reg > SLOTS) return SLOTS;
      return win_reg;
   endfunction

   function automatic int unsigned words_eff();
      if (words_reg == 0) return 1;
      if (words_reg > WORDS_MAX) return WORDS_MAX;
      return words_reg;
   endfunction

   function automatic void window_restart();
      for (int i = 0; i < SLOTS; i++) begin
         slot_ok[i]  = 1'b0;
         slot_len[i] = '0;
      end
      // stored payload is unspecified after reset; staging words restart at zero
      for (int i = 0; i < SLOTS*WORDS_MAX; i++) pkt_known[i] = 1'b0;
      for (int i = 0; i < WORDS_MAX; i++) begin
         stage_mem[i]   = '0;
         stage_known[i] = 1'b1;
      end
      low_edge = init_seq_reg;
      cur_edge = init_seq_reg;
      up_edge  = init_seq_reg + win_eff();
   endfunction

   function automatic void invalidate_run(logic [31:0] from, logic [31:0] to, bit zero_len);
      int unsigned w, n, s, idx;
      w = win_eff();
      if (to <= from) return;
      n = to - from;
      if (n > w) n = w;
      s = from % w;
      for (int unsigned k = 0; k < n; k++) begin
         idx = (s + k) % w;
         slot_ok[idx] = 1'b0;
         if (zero_len) slot_len[idx] = '0;
      end
   endfunction

   function automatic bit slot_readable(int unsigned slot);
      for (int k = 0; k < words_eff(); k++)
         if (!pkt_known[slot*WORDS_MAX + k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type make_rsp(bit status, logic [63:0] word, logic [15:0] len,
                                        logic [3:0] widx, bit last, int unsigned slot,
                                        logic [8:0] count);
      rsp_type r;
      r.status         = status;
      r.out_data_word  = word;
      r.out_data_size  = len;
      r.out_word_index = widx;
      r.last_result    = last;
      r.window_open    = (cur_edge != up_edge);
      r.entry_valid    = slot_ok[slot % SLOTS];
      r.in_order_count = count;
      r.lower_seq      = low_edge;
      return r;
   endfunction

   // Applies one accepted request to the model and queues the responses it causes.
   function automatic void predict_window(op_type op, logic [31:0] seq, logic [15:0] len,
                                          logic [3:0] widx, logic [63:0] word, bit last);
      int unsigned w, n, seq_slot, slot, cnt;
      bit          status;
      logic [31:0] pos;
      w        = win_eff();
      n        = words_eff();
      seq_slot = seq % w;
      status   = 1'b0;
      cnt      = 0;
      case (op)
         OP_RESET: begin
            window_restart();
            expected_rsp_q.push_back(make_rsp(0, 0, 0, 0, 1, init_seq_reg % win_eff(), 0));
         end
         OP_ADD, OP_REPLACE: begin
            stage_mem[widx]   = word;
            stage_known[widx] = 1'b1;
            if (last) begin
               if (op == OP_ADD && cur_edge == up_edge) begin
                  status = 1'b1;   // window closed, nothing moves
               end else begin
                  if (op == OP_ADD) invalidate_run(cur_edge, seq, 1'b1);
                  for (int k = 0; k < n; k++) begin
                     pkt_mem[seq_slot*WORDS_MAX + k]   = stage_mem[k];
                     pkt_known[seq_slot*WORDS_MAX + k] = stage_known[k];
                  end
                  slot_ok[seq_slot]  = 1'b1;
                  slot_len[seq_slot] = len;
                  if (op == OP_ADD) cur_edge = seq + 1;
               end
               expected_rsp_q.push_back(make_rsp(status, 0, 0, 0, 1, seq_slot, 0));
            end
         end
         OP_GET, OP_GET_LOW: begin
            slot = (op == OP_GET) ? seq_slot : (low_edge % w);
            for (int k = 0; k < n; k++)
               expected_rsp_q.push_back(make_rsp(0, pkt_mem[slot*WORDS_MAX + k],
                                                 slot_len[slot], k, k + 1 == n, slot, 0));
         end
         OP_QUERY:
            expected_rsp_q.push_back(make_rsp(0, 0, 0, 0, 1, seq_slot, 0));
         OP_SLIDE: begin
            invalidate_run(low_edge, seq, 1'b0);
            low_edge = seq;
            up_edge  = seq + w;
            expected_rsp_q.push_back(make_rsp(0, 0, 0, 0, 1, seq_slot, 0));
         end
         default: begin
            pos = low_edge;
            while (pos < cur_edge && cnt < w && slot_ok[pos % w]) begin
               cnt++;
               pos++;
            end
            expected_rsp_q.push_back(make_rsp(0, 0, 0, 0, 1, seq_slot, cnt));
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Response side: stall pattern and checker
   // ---------------------------------------------------------------
   int rx_cycle;
   int rx_mode;

   initial begin
      req.valid      = 1'b0;
      req.op         = OP_QUERY;
      req.seq_num    = '0;
      req.data_size  = '0;
      req.word_index = '0;
      req.data_word  = '0;
      req.last_word  = 1'b0;
      rsp.ready      = 1'b0;
      rx_cycle       = 0;
      rx_mode        = 0;
   end

   // ready follows a randomly redrawn mode: free, coin flip, one in three
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 50 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
         0:       rsp.ready <= 1'b1;
         1:       rsp.ready <= $urandom_range(0, 1);
         default: rsp.ready <= (rx_cycle % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_xfers++;
         if (expected_rsp_q.size() == 0) begin
            $error("response transfer with nothing expected");
            fails++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp.status !== want.status) begin
               $error("status exp %0h got %0h", want.status, rsp.status); fails++;
            end
            if (rsp.out_data_word !== want.out_data_word) begin
               $error("out_data_word exp %0h got %0h", want.out_data_word, rsp.out_data_word);
               fails++;
            end
            if (rsp.out_data_size !== want.out_data_size) begin
               $error("out_data_size exp %0h got %0h", want.out_data_size, rsp.out_data_size);
               fails++;
            end
            if (rsp.out_word_index !== want.out_word_index) begin
               $error("out_word_index exp %0h got %0h", want.out_word_index,
                      rsp.out_word_index);
               fails++;
            end
            if (rsp.last_result !== want.last_result) begin
               $error("last_result exp %0h got %0h", want.last_result, rsp.last_result);
               fails++;
            end
            if (rsp.window_open !== want.window_open) begin
               $error("window_open exp %0h got %0h", want.window_open, rsp.window_open);
               fails++;
            end
            if (rsp.entry_valid !== want.entry_valid) begin
               $error("entry_valid exp %0h got %0h", want.entry_valid, rsp.entry_valid);
               fails++;
            end
            if (rsp.in_order_count !== want.in_order_count) begin
               $error("in_order_count exp %0h got %0h", want.in_order_count,
                      rsp.in_order_count);
               fails++;
            end
            if (rsp.lower_seq !== want.lower_seq) begin
               $error("lower_seq exp %0h got %0h", want.lower_seq, rsp.lower_seq);
               fails++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   int burst_left;

   // One request transfer; valid stays high into the next call inside a burst.
   task automatic send_req(op_type op, logic [31:0] seq, logic [15:0] len,
                           logic [3:0] widx, logic [63:0] word, bit last);
      int gap;
      // never read payload that was not written since reset
      if (op == OP_GET && !slot_readable(seq % win_eff())) op = OP_QUERY;
      if (op == OP_GET_LOW && !slot_readable(low_edge % win_eff())) op = OP_QUERY;
      @(negedge clock);
      req.valid      = 1'b1;
      req.op         = op;
      req.seq_num    = seq;
      req.data_size  = len;
      req.word_index = widx;
      req.data_word  = word;
      req.last_word  = last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_window(op, seq, len, widx, word, last);
      req_xfers++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
   endtask

   // Drop valid and wait until every expected response has been seen.
   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      wait (expected_rsp_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         CSR_WINDOW_SIZE:  win_reg      = data[8:0];
         CSR_PACKET_WORDS: words_reg    = data[4:0];
         default:          init_seq_reg = data;
      endcase
   endtask

   task automatic send_packet(op_type op, logic [31:0] seq);
      logic [15:0] len;
      int n;
      len = $urandom;
      n   = words_eff();
      for (int k = 0; k < n; k++)
         send_req(op, seq, len, k, {$urandom, $urandom}, k == n - 1);
   endtask

   // Whole packets near the current edge as the largest share, plus lookups, slides, counts, resets and noise words.
   task automatic random_phase(int budget);
      int start, r, w;
      start = req_xfers;
      while (req_xfers - start < budget) begin
         w = win_eff();
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send_packet($urandom_range(0, 4) == 0 ? OP_REPLACE : OP_ADD,
                        $urandom_range(0, 5) == 0 ? $urandom
                                                  : cur_edge + $urandom_range(0, 2));
         end else if (r < 47) begin
            // stray staging word, never committed here
            send_req($urandom_range(0, 1) ? OP_ADD : OP_REPLACE, $urandom, $urandom,
                     $urandom_range(0, 15), {$urandom, $urandom}, 1'b0);
         end else if (r < 60) begin
            send_req(OP_GET, low_edge + $urandom_range(0, w - 1), 0, 0, 0, 0);
         end else if (r < 68) begin
            send_req(OP_GET_LOW, $urandom, 0, 0, 0, 0);
         end else if (r < 76) begin
            send_req(OP_QUERY, $urandom_range(0, 1) ? $urandom : cur_edge, 0, 0, 0, 0);
         end else if (r < 87) begin
            send_req(OP_SLIDE, $urandom_range(0, 7) == 0 ? $urandom
                                                         : low_edge + $urandom_range(0, w),
                     0, 0, 0, 0);
         end else if (r < 97) begin
            send_req(OP_COUNT, $urandom, 0, 0, 0, 0);
         end else begin
            send_req(OP_RESET, $urandom, 0, 0, 0, 0);
         end
         if ($urandom_range(0, 24) == 0) drain();
      end
   endtask

   // Directed rows: first three run with reset defaults, the rest with a 4-slot window,
   // 2-word packets and edges just below the 32-bit wrap.
   stim_row_type dir_rows[] = '{
      '{OP_QUERY,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b1,
        '{1'b0, 64'h0, 16'h0, 4'h0, 1'b1, 1'b1, 1'b0, 9'd0, 32'h0}},
      '{OP_COUNT,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b1,
        '{1'b0, 64'h0, 16'h0, 4'h0, 1'b1, 1'b1, 1'b0, 9'd0, 32'h0}},
      '{OP_RESET,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b1,
        '{1'b0, 64'h0, 16'h0, 4'h0, 1'b1, 1'b1, 1'b0, 9'd0, 32'h0}},
      '{OP_RESET,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b1,
        '{1'b0, 64'h0, 16'h0, 4'h0, 1'b1, 1'b1, 1'b0, 9'd0, 32'hFFFF_FFFE}},
      '{OP_ADD,     32'hFFFF_FFFE, 16'hFFFF, 4'd0, '1,     1'b0, 1'b0, '{default:'0}},
      '{OP_ADD,     32'hFFFF_FFFE, 16'hFFFF, 4'd1, 64'h0,  1'b1, 1'b0, '{default:'0}},
      '{OP_ADD,     32'h1,        16'h0,    4'd1,  64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0,
        '{default:'0}},
      // add at sequence 1 wraps past the current edge: no gap is cleared
      '{OP_ADD,     32'h1,        16'h0,    4'd0,  64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0,
        '{default:'0}},
      // current equals upper: add rejected
      '{OP_ADD,     32'h5,        16'h7,    4'd0,  64'h1,  1'b1, 1'b1,
        '{1'b1, 64'h0, 16'h0, 4'h0, 1'b1, 1'b0, 1'b1, 9'd0, 32'hFFFF_FFFE}},
      '{OP_GET,     32'hFFFF_FFFE, 16'h0,   4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      '{OP_GET_LOW, 32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      '{OP_COUNT,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      // word index past the packet length is staged but not committed
      '{OP_REPLACE, 32'h2,        16'h1234, 4'd15, '1,     1'b0, 1'b0, '{default:'0}},
      '{OP_REPLACE, 32'h2,        16'h1234, 4'd0,  64'h8000_0000_0000_0001, 1'b1, 1'b0,
        '{default:'0}},
      '{OP_QUERY,   32'h2,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      // slide target wraps below the lower edge: nothing invalidated
      '{OP_SLIDE,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      '{OP_COUNT,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      // add with a one-slot gap
      '{OP_ADD,     32'h3,        16'h00FF, 4'd0,  64'h5555_5555_5555_5555, 1'b1, 1'b0,
        '{default:'0}},
      '{OP_GET,     32'h3,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      '{OP_SLIDE,   32'hFFFF_FFF0, 16'h0,   4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      '{OP_COUNT,   32'hFFFF_FFFF, 16'h0,   4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}},
      '{OP_RESET,   32'h0,        16'h0,    4'd0,  64'h0,  1'b0, 1'b0, '{default:'0}}
   };

   initial begin
      logic [8:0]  win_pick;
      logic [4:0]  words_pick;
      logic [31:0] init_pick;
      req_xfers  = 0;
      rsp_xfers  = 0;
      fails      = 0;
      phases     = 0;
      burst_left = $urandom_range(1, 10);
      win_reg      = WIN_RST;
      words_reg    = WORDS_RST;
      init_seq_reg = INIT_SEQ_RST;
      window_restart();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (i == 3) begin
            drain();
            csr_write(CSR_WINDOW_SIZE, 4);
            csr_write(CSR_PACKET_WORDS, 2);
            csr_write(CSR_INIT_SEQ, 32'hFFFF_FFFE);
         end
         send_req(dir_rows[i].op, dir_rows[i].seq, dir_rows[i].size, dir_rows[i].widx,
                  dir_rows[i].word, dir_rows[i].last);
         if (dir_rows[i].typed) begin
            void'(expected_rsp_q.pop_back());
            expected_rsp_q.push_back(dir_rows[i].res);
         end
      end

      // Random phases, each with its own register setting; extremes come first.
      while (req_xfers < 130) begin
         drain();
         case (phases % 6)
            0: begin win_pick = 1;   words_pick = 1;  end
            1: begin win_pick = 256; words_pick = 16; end
            2: begin win_pick = 0;   words_pick = 0;  end
            3: begin win_pick = 511; words_pick = 31; end
            default: begin
               win_pick   = $urandom_range(2, 12);
               words_pick = $urandom_range(1, 4);
            end
         endcase
         init_pick = phases[0] ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
         csr_write(CSR_WINDOW_SIZE, win_pick);
         csr_write(CSR_PACKET_WORDS, words_pick);
         csr_write(CSR_INIT_SEQ, init_pick);
         send_req(OP_RESET, $urandom, 0, 0, 0, 0);
         random_phase(25);
         phases++;
      end

      drain();
      $display("summary: %0d request transfers, %0d response transfers checked",
               req_xfers, rsp_xfers);
      $display("summary: %0d random register settings incl. window 0/1/256/511, words 0/1/16/31",
               phases);
      if (fails == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
design/swpb_pkg.sv
design/swpb_req_if.sv
design/swpb_rsp_if.sv
design/swpb_rem.sv
design/sliding_window_packet_buffer.sv
design/swpb_chk.sv
test/testbench.sv
